// ----- src/tbg_pkg.sv -----
// shared constants and payload types for the tight-binding green integrand block
// no dependencies; every other file refers to this package by scoped names
package tbg_pkg;

    localparam int FRAC_BITS = 16;

    // register indexes, byte address is four times the index
    typedef enum logic [2:0] {
        REG_HOP_T,
        REG_HOP_T1,
        REG_FIELD_H,
        REG_CHEM_MU,
        REG_FREQ_RE,
        REG_FREQ_IM
    } cfg_reg_t;

    // cosine series in q30
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam int          HORNER_N    = 7;
    localparam logic [7:0]  HORNER_DIV [HORNER_N] =
        '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

    // fold, angle scale, square, three stages per horner step, sign
    localparam int COS_LAT = 3 + 3 * HORNER_N + 1;

    // complex reciprocal
    localparam int DRE_W    = 40;
    localparam int DIM_W    = 33;
    localparam int QUOT_W   = 34;
    localparam int DIV_BITS = 2;
    localparam int DIV_ST   = QUOT_W / DIV_BITS;
    localparam int RCP_LAT  = 6 + DIV_ST + 2;

    typedef struct packed {
        logic [15:0]        kx;
        logic [15:0]        ky;
        logic signed [31:0] se_re;
        logic signed [31:0] se_im;
    } tbg_in_t;

    typedef struct packed {
        logic signed [31:0] g_re;
        logic signed [31:0] g_im;
        logic               div_zero;
        logic               saturated;
    } tbg_out_t;

endpackage

// ----- src/tbg_cos.sv -----
// pipelined two-lane cosine: quadrant fold, q30 angle, taylor series by horner steps
// depends on tbg_pkg
module tbg_cos (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [15:0]        ang_x,
    input  logic [15:0]        ang_y,
    output logic               out_valid,
    output logic signed [31:0] cos_x,
    output logic signed [31:0] cos_y
);

    localparam int NL = 2;
    localparam int NH = tbg_pkg::HORNER_N;

    logic [tbg_pkg::COS_LAT-1:0] vld_reg;
    logic [15:0]                 ang      [NL];
    logic [14:0]                 fold_reg [NL];
    logic                        fneg_reg [NL];
    logic [30:0]                 x_reg    [NL];
    logic                        xneg_reg [NL];
    logic [31:0]                 x2_reg   [NL];
    logic                        x2neg_reg[NL];

    logic [61:0] prod_reg [NL][NH];
    logic [31:0] v_reg    [NL][NH];
    logic [63:0] pm_reg   [NL][NH];
    logic [30:0] t_reg    [NL][NH];
    logic [31:0] x2a_reg  [NL][NH];
    logic [31:0] x2b_reg  [NL][NH];
    logic [31:0] x2c_reg  [NL][NH];
    logic        nega_reg [NL][NH];
    logic        negb_reg [NL][NH];
    logic        negc_reg [NL][NH];

    logic signed [31:0] cos_reg [NL];

    // returns {negate, folded angle in [0, quarter turn]}
    function automatic logic [15:0] fold(input logic [15:0] a_in);
        logic [16:0] a;
        logic        neg;
        a   = {1'b0, a_in};
        neg = 1'b0;
        if (a > 17'd32768)
        begin
            a = 17'd65536 - a;
        end
        if (a > 17'd16384)
        begin
            neg = 1'b1;
            a   = 17'd32768 - a;
        end
        return {neg, a[14:0]};
    endfunction

    assign ang[0] = ang_x;
    assign ang[1] = ang_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[tbg_pkg::COS_LAT-2:0], in_valid};
        end
    end

    for (genvar l = 0; l < NL; l++)
    begin : g_lane
        logic [15:0] folded;

        assign folded = fold(ang[l]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                fold_reg[l]  <= folded[14:0];
                fneg_reg[l]  <= folded[15];
                x_reg[l]     <= 31'((46'(fold_reg[l]) * 46'(tbg_pkg::HALF_PI_Q30)) >> 14);
                xneg_reg[l]  <= fneg_reg[l];
                x2_reg[l]    <= 32'((62'(x_reg[l]) * 62'(x_reg[l])) >> 30);
                x2neg_reg[l] <= xneg_reg[l];
            end
        end

        for (genvar i = 0; i < NH; i++)
        begin : g_step
            localparam logic [7:0]  D   = tbg_pkg::HORNER_DIV[i];
            localparam logic [31:0] RCP = 32'((64'd1 << 32) / D);

            logic [30:0] t_src;
            logic [31:0] x2_src;
            logic        neg_src;
            logic [31:0] q0;
            logic [39:0] rem;
            logic [31:0] q;
            logic [30:0] t_next;

            if (i == 0)
            begin : g_first
                assign t_src   = tbg_pkg::ONE_Q30;
                assign x2_src  = x2_reg[l];
                assign neg_src = x2neg_reg[l];
            end
            else
            begin : g_next
                assign t_src   = t_reg[l][i-1];
                assign x2_src  = x2c_reg[l][i-1];
                assign neg_src = negc_reg[l][i-1];
            end

            // divide by a small constant: reciprocal estimate is low by at most one
            always_comb
            begin
                q0  = pm_reg[l][i][63:32];
                rem = 40'(v_reg[l][i]) - 40'(q0) * 40'(D);
                q   = (rem >= 40'(D)) ? q0 + 32'd1 : q0;
                t_next = (q >= 32'(tbg_pkg::ONE_Q30)) ? '0 : tbg_pkg::ONE_Q30 - q[30:0];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    prod_reg[l][i] <= 62'(x2_src) * 62'(t_src);
                    x2a_reg[l][i]  <= x2_src;
                    nega_reg[l][i] <= neg_src;
                    v_reg[l][i]    <= prod_reg[l][i][61:30];
                    pm_reg[l][i]   <= 64'(prod_reg[l][i][61:30]) * 64'(RCP);
                    x2b_reg[l][i]  <= x2a_reg[l][i];
                    negb_reg[l][i] <= nega_reg[l][i];
                    t_reg[l][i]    <= t_next;
                    x2c_reg[l][i]  <= x2b_reg[l][i];
                    negc_reg[l][i] <= negb_reg[l][i];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cos_reg[l] <= negc_reg[l][NH-1] ? -$signed({1'b0, t_reg[l][NH-1]})
                                                :  $signed({1'b0, t_reg[l][NH-1]});
            end
        end
    end

    assign out_valid = vld_reg[tbg_pkg::COS_LAT-1];
    assign cos_x     = cos_reg[0];
    assign cos_y     = cos_reg[1];

    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cos_x <= 32'sd1073741824 && cos_x >= -32'sd1073741824 &&
                       cos_y <= 32'sd1073741824 && cos_y >= -32'sd1073741824))
        else $error("cosine outside unit range");

endmodule

// ----- src/tbg_recip.sv -----
// pipelined complex reciprocal: normalize, square, restoring divide, rescale and clip
// depends on tbg_pkg
module tbg_recip (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [tbg_pkg::DRE_W-1:0]     dre,
    input  logic signed [tbg_pkg::DIM_W-1:0]     dim,
    output logic                                 out_valid,
    output tbg_pkg::tbg_out_t                    out_data
);

    localparam int NS = tbg_pkg::DIV_ST;
    localparam int NG = tbg_pkg::DRE_W / 8;

    logic [tbg_pkg::RCP_LAT-1:0] vld_reg;

    // normalize stages
    logic [39:0] r1_ma_reg, r1_mm_reg;
    logic [32:0] r1_mb_reg;
    logic        r1_sa_reg, r1_sb_reg;
    logic [39:0] r2_ma_reg;
    logic [32:0] r2_mb_reg;
    logic [2:0]  r2_grp_reg;
    logic [7:0]  r2_byte_reg;
    logic        r2_sa_reg, r2_sb_reg, r2_dz_reg;
    logic [39:0] r3_ma_reg;
    logic [32:0] r3_mb_reg;
    logic signed [6:0] r3_s_reg;
    logic        r3_sa_reg, r3_sb_reg, r3_dz_reg;
    logic [30:0] r4_ap_reg, r4_bp_reg;
    logic signed [7:0] r4_ex_reg;
    logic        r4_sa_reg, r4_sb_reg, r4_dz_reg;
    logic [61:0] r5_sqa_reg, r5_sqb_reg;
    logic [30:0] r5_ap_reg, r5_bp_reg;
    logic signed [7:0] r5_ex_reg;
    logic        r5_sa_reg, r5_sb_reg, r5_dz_reg;

    // divider stages, index 0 is the loaded stage
    logic [32:0] den_reg   [NS+1];
    logic [32:0] rema_reg  [NS+1];
    logic [32:0] remb_reg  [NS+1];
    logic [33:0] feeda_reg [NS+1];
    logic [33:0] feedb_reg [NS+1];
    logic [33:0] quota_reg [NS+1];
    logic [33:0] quotb_reg [NS+1];
    logic signed [7:0] ex_reg [NS+1];
    logic        sa_reg [NS+1];
    logic        sb_reg [NS+1];
    logic        dz_reg [NS+1];

    // rescale and output
    logic [66:0] s1_qva_reg, s1_qvb_reg;
    logic        s1_biga_reg, s1_bigb_reg, s1_sa_reg, s1_sb_reg, s1_dz_reg;
    tbg_pkg::tbg_out_t out_reg;

    logic [39:0] ma_c, mm_c;
    logic [32:0] mb_c;
    logic [2:0]  grp_c;
    logic [2:0]  fine_c;
    logic signed [6:0] s_c;
    logic [6:0]  nsh_c;
    logic [71:0] sha_c, shb_c;
    logic [67:0] sca_c, scb_c;
    logic [32:0] ca_c, cb_c;

    function automatic logic [100:0] div_step(input logic [32:0] rem, input logic [33:0] feed,
                                              input logic [33:0] quot, input logic [32:0] den);
        logic [33:0] r2;
        logic        qb;
        r2 = {rem, feed[33]};
        qb = (r2 >= {1'b0, den});
        if (qb)
        begin
            r2 = r2 - {1'b0, den};
        end
        return {r2[32:0], feed[32:0], 1'b0, quot[32:0], qb};
    endfunction

    // returns {overflow, scaled quotient}
    function automatic logic [67:0] scale(input logic [33:0] q, input logic signed [7:0] ex);
        logic [66:0] v;
        logic        big;
        logic [7:0]  sh;
        v   = '0;
        big = 1'b0;
        sh  = 8'(-ex);
        if (!ex[7])
        begin
            if (ex > 8'sd32)
            begin
                big = (q != '0);
            end
            else
            begin
                v = 67'(q) << ex[5:0];
            end
        end
        else if (sh < 8'd63)
        begin
            v = 67'((64'(q) + (64'd1 << (sh - 8'd1))) >> sh);
        end
        return {big, v};
    endfunction

    // returns {clipped, signed result}
    function automatic logic [32:0] clip(input logic big, input logic [66:0] qv,
                                         input logic neg);
        logic [66:0] lim;
        logic        sat;
        logic [31:0] m;
        lim = neg ? 67'h8000_0000 : 67'h7FFF_FFFF;
        sat = big || (qv > lim);
        m   = sat ? lim[31:0] : qv[31:0];
        return {sat, neg ? 32'(-m) : m};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[tbg_pkg::RCP_LAT-2:0], in_valid};
        end
    end

    always_comb
    begin
        ma_c = dre[39] ? 40'(-dre) : 40'(dre);
        mb_c = dim[32] ? 33'(-dim) : 33'(dim);
        mm_c = (ma_c > 40'(mb_c)) ? ma_c : 40'(mb_c);

        // coarse leading-one search by bytes
        grp_c = '0;
        for (int k = 0; k < NG; k++)
        begin
            if (r1_mm_reg[8*k +: 8] != '0)
            begin
                grp_c = 3'(k);
            end
        end

        fine_c = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (r2_byte_reg[k])
            begin
                fine_c = 3'(k);
            end
        end
        s_c = 7'sd30 - $signed({1'b0, r2_grp_reg, fine_c});

        nsh_c = 7'(-r3_s_reg);
        sha_c = r3_s_reg[6] ? (72'(r3_ma_reg) >> nsh_c) : (72'(r3_ma_reg) << r3_s_reg[5:0]);
        shb_c = r3_s_reg[6] ? (72'(r3_mb_reg) >> nsh_c) : (72'(r3_mb_reg) << r3_s_reg[5:0]);

        sca_c = scale(quota_reg[NS], ex_reg[NS]);
        scb_c = scale(quotb_reg[NS], ex_reg[NS]);

        ca_c = clip(s1_biga_reg, s1_qva_reg, s1_sa_reg);
        cb_c = clip(s1_bigb_reg, s1_qvb_reg, s1_sb_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_ma_reg <= ma_c;
            r1_mb_reg <= mb_c;
            r1_mm_reg <= mm_c;
            r1_sa_reg <= dre[39];
            r1_sb_reg <= !dim[32] && (dim != '0);

            r2_ma_reg   <= r1_ma_reg;
            r2_mb_reg   <= r1_mb_reg;
            r2_grp_reg  <= grp_c;
            r2_byte_reg <= r1_mm_reg[8*grp_c +: 8];
            r2_sa_reg   <= r1_sa_reg;
            r2_sb_reg   <= r1_sb_reg;
            r2_dz_reg   <= (r1_mm_reg == '0);

            r3_ma_reg <= r2_ma_reg;
            r3_mb_reg <= r2_mb_reg;
            r3_s_reg  <= s_c;
            r3_sa_reg <= r2_sa_reg;
            r3_sb_reg <= r2_sb_reg;
            r3_dz_reg <= r2_dz_reg;

            r4_ap_reg <= sha_c[30:0];
            r4_bp_reg <= shb_c[30:0];
            r4_ex_reg <= 8'(2 * tbg_pkg::FRAC_BITS - 61) + 8'(r3_s_reg);
            r4_sa_reg <= r3_sa_reg;
            r4_sb_reg <= r3_sb_reg;
            r4_dz_reg <= r3_dz_reg;

            r5_sqa_reg <= 62'(r4_ap_reg) * 62'(r4_ap_reg);
            r5_sqb_reg <= 62'(r4_bp_reg) * 62'(r4_bp_reg);
            r5_ap_reg  <= r4_ap_reg;
            r5_bp_reg  <= r4_bp_reg;
            r5_ex_reg  <= r4_ex_reg;
            r5_sa_reg  <= r4_sa_reg;
            r5_sb_reg  <= r4_sb_reg;
            r5_dz_reg  <= r4_dz_reg;

            // dividend is part << 31; its top bits already sit below the divisor
            den_reg[0]   <= 33'((63'(r5_sqa_reg) + 63'(r5_sqb_reg)) >> 30);
            rema_reg[0]  <= 33'(r5_ap_reg[30:3]);
            remb_reg[0]  <= 33'(r5_bp_reg[30:3]);
            feeda_reg[0] <= {r5_ap_reg[2:0], 31'b0};
            feedb_reg[0] <= {r5_bp_reg[2:0], 31'b0};
            quota_reg[0] <= '0;
            quotb_reg[0] <= '0;
            ex_reg[0]    <= r5_ex_reg;
            sa_reg[0]    <= r5_sa_reg;
            sb_reg[0]    <= r5_sb_reg;
            dz_reg[0]    <= r5_dz_reg;

            s1_biga_reg <= sca_c[67];
            s1_qva_reg  <= sca_c[66:0];
            s1_bigb_reg <= scb_c[67];
            s1_qvb_reg  <= scb_c[66:0];
            s1_sa_reg   <= sa_reg[NS];
            s1_sb_reg   <= sb_reg[NS];
            s1_dz_reg   <= dz_reg[NS];

            out_reg.g_re      <= s1_dz_reg ? '0 : $signed(ca_c[31:0]);
            out_reg.g_im      <= s1_dz_reg ? '0 : $signed(cb_c[31:0]);
            out_reg.div_zero  <= s1_dz_reg;
            out_reg.saturated <= !s1_dz_reg && (ca_c[32] || cb_c[32]);
        end
    end

    for (genvar k = 1; k <= NS; k++)
    begin : g_div
        logic [32:0] ra, rb;
        logic [33:0] fa, fb, qa, qb;

        always_comb
        begin
            ra = rema_reg[k-1];
            fa = feeda_reg[k-1];
            qa = quota_reg[k-1];
            rb = remb_reg[k-1];
            fb = feedb_reg[k-1];
            qb = quotb_reg[k-1];
            for (int j = 0; j < tbg_pkg::DIV_BITS; j++)
            begin
                {ra, fa, qa} = div_step(ra, fa, qa, den_reg[k-1]);
                {rb, fb, qb} = div_step(rb, fb, qb, den_reg[k-1]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[k]   <= den_reg[k-1];
                rema_reg[k]  <= ra;
                remb_reg[k]  <= rb;
                feeda_reg[k] <= fa;
                feedb_reg[k] <= fb;
                quota_reg[k] <= qa;
                quotb_reg[k] <= qb;
                ex_reg[k]    <= ex_reg[k-1];
                sa_reg[k]    <= sa_reg[k-1];
                sb_reg[k]    <= sb_reg[k-1];
                dz_reg[k]    <= dz_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[tbg_pkg::RCP_LAT-1];
    assign out_data  = out_reg;

    a_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[3] && !r4_dz_reg) |-> (r4_ap_reg[30] || r4_bp_reg[30]))
        else $error("normalized parts miss the target range");

    a_den_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[5] && !dz_reg[0]) |-> (den_reg[0][32:30] != 3'b000))
        else $error("divisor below 2^30 after normalization");

endmodule

// ----- src/tight_binding_green_integrand.sv -----
// top level: apb register file, band energy pipeline, output register
// depends on tbg_pkg, tbg_cos, tbg_recip
// path from input transfer to result valid: cosine, band energy, reciprocal, then output register
// throughput: one item per cycle; the whole pipeline advances unless a held result is not taken
// the stage count is set by the seven horner steps of the cosine and the radix-4 divider
// reset: valid bits and output valid clear; registers return to t = 1.0, all others zero
module tight_binding_green_integrand (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  tbg_pkg::tbg_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tbg_pkg::tbg_out_t out_data
);

    localparam int CL = tbg_pkg::COS_LAT;

    logic signed [31:0] hop_t_reg, hop_t1_reg, field_h_reg, chem_mu_reg, freq_re_reg, freq_im_reg;
    tbg_pkg::cfg_reg_t  cfg_idx;
    logic               en;

    logic               cos_valid;
    logic signed [31:0] cos_x, cos_y;
    logic signed [31:0] se_re_dly_reg [CL];
    logic signed [31:0] se_im_dly_reg [CL];

    logic [4:0]         bvld_reg;
    logic signed [32:0] b1_sum_reg;
    logic [60:0]        b1_pxy_reg;
    logic               b1_pneg_reg;
    logic signed [31:0] b1_se_re_reg, b1_se_im_reg;
    logic [63:0]        b2_p1_reg;
    logic               b2_p1neg_reg;
    logic [30:0]        b2_cxy_reg;
    logic               b2_cneg_reg;
    logic signed [31:0] b2_se_re_reg, b2_se_im_reg;
    logic signed [39:0] b3_p1s_reg;
    logic [62:0]        b3_p2_reg;
    logic               b3_p2neg_reg;
    logic signed [31:0] b3_se_re_reg, b3_se_im_reg;
    logic signed [39:0] b4_band_reg;
    logic signed [31:0] b4_se_re_reg, b4_se_im_reg;
    logic signed [39:0] b5_dre_reg;
    logic signed [32:0] b5_dim_reg;

    logic [30:0]        cx_mag, cy_mag;
    logic [31:0]        t_mag, t1_mag, sum_mag;
    logic [33:0]        p1_rnd, p2_rnd;
    logic signed [39:0] p2s;

    logic               rcp_valid;
    tbg_pkg::tbg_out_t  rcp_out;
    logic               out_valid_reg;
    tbg_pkg::tbg_out_t  out_data_reg;

    assign cfg_idx  = tbg_pkg::cfg_reg_t'(paddr[4:2]);
    assign pready   = 1'b1;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop_t_reg   <= 32'sd1 <<< tbg_pkg::FRAC_BITS;
            hop_t1_reg  <= '0;
            field_h_reg <= '0;
            chem_mu_reg <= '0;
            freq_re_reg <= '0;
            freq_im_reg <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (cfg_idx)
                tbg_pkg::REG_HOP_T:   hop_t_reg   <= pwdata;
                tbg_pkg::REG_HOP_T1:  hop_t1_reg  <= pwdata;
                tbg_pkg::REG_FIELD_H: field_h_reg <= pwdata;
                tbg_pkg::REG_CHEM_MU: chem_mu_reg <= pwdata;
                tbg_pkg::REG_FREQ_RE: freq_re_reg <= pwdata;
                tbg_pkg::REG_FREQ_IM: freq_im_reg <= pwdata;
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            tbg_pkg::REG_HOP_T:   prdata = hop_t_reg;
            tbg_pkg::REG_HOP_T1:  prdata = hop_t1_reg;
            tbg_pkg::REG_FIELD_H: prdata = field_h_reg;
            tbg_pkg::REG_CHEM_MU: prdata = chem_mu_reg;
            tbg_pkg::REG_FREQ_RE: prdata = freq_re_reg;
            tbg_pkg::REG_FREQ_IM: prdata = freq_im_reg;
            default:              prdata = '0;
        endcase
    end

    tbg_cos u_cos (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .ang_x     (in_data.kx),
        .ang_y     (in_data.ky),
        .out_valid (cos_valid),
        .cos_x     (cos_x),
        .cos_y     (cos_y)
    );

    // self-energy rides alongside the cosine pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            se_re_dly_reg[0] <= in_data.se_re;
            se_im_dly_reg[0] <= in_data.se_im;
            for (int k = 1; k < CL; k++)
            begin
                se_re_dly_reg[k] <= se_re_dly_reg[k-1];
                se_im_dly_reg[k] <= se_im_dly_reg[k-1];
            end
        end
    end

    always_comb
    begin
        cx_mag  = cos_x[31] ? 31'(-cos_x) : cos_x[30:0];
        cy_mag  = cos_y[31] ? 31'(-cos_y) : cos_y[30:0];
        t_mag   = hop_t_reg[31] ? 32'(-hop_t_reg) : hop_t_reg;
        t1_mag  = hop_t1_reg[31] ? 32'(-hop_t1_reg) : hop_t1_reg;
        sum_mag = b1_sum_reg[32] ? 32'(-b1_sum_reg) : b1_sum_reg[31:0];
        p1_rnd  = 34'((b2_p1_reg + (64'd1 << 28)) >> 29);
        p2_rnd  = 34'((64'(b3_p2_reg) + (64'd1 << 27)) >> 28);
        p2s     = b3_p2neg_reg ? -$signed(40'(p2_rnd)) : $signed(40'(p2_rnd));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bvld_reg <= '0;
        end
        else if (en)
        begin
            bvld_reg <= {bvld_reg[3:0], cos_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_sum_reg   <= 33'(cos_x) + 33'(cos_y);
            b1_pxy_reg   <= 61'(cx_mag) * 61'(cy_mag);
            b1_pneg_reg  <= cos_x[31] ^ cos_y[31];
            b1_se_re_reg <= se_re_dly_reg[CL-1];
            b1_se_im_reg <= se_im_dly_reg[CL-1];

            b2_p1_reg    <= 64'(t_mag) * 64'(sum_mag);
            b2_p1neg_reg <= hop_t_reg[31] ^ b1_sum_reg[32];
            b2_cxy_reg   <= 31'((b1_pxy_reg + (61'd1 << 29)) >> 30);
            b2_cneg_reg  <= b1_pneg_reg;
            b2_se_re_reg <= b1_se_re_reg;
            b2_se_im_reg <= b1_se_im_reg;

            b3_p1s_reg   <= b2_p1neg_reg ? -$signed(40'(p1_rnd)) : $signed(40'(p1_rnd));
            b3_p2_reg    <= 63'(t1_mag) * 63'(b2_cxy_reg);
            b3_p2neg_reg <= hop_t1_reg[31] ^ b2_cneg_reg;
            b3_se_re_reg <= b2_se_re_reg;
            b3_se_im_reg <= b2_se_im_reg;

            b4_band_reg  <= -b3_p1s_reg - p2s - 40'(field_h_reg);
            b4_se_re_reg <= b3_se_re_reg;
            b4_se_im_reg <= b3_se_im_reg;

            b5_dre_reg   <= 40'(freq_re_reg) + 40'(chem_mu_reg) - b4_band_reg - 40'(b4_se_re_reg);
            b5_dim_reg   <= 33'(freq_im_reg) - 33'(b4_se_im_reg);
        end
    end

    tbg_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (bvld_reg[4]),
        .dre       (b5_dre_reg),
        .dim       (b5_dim_reg),
        .out_valid (rcp_valid),
        .out_data  (rcp_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= rcp_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= rcp_out;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.div_zero) |->
            (out_data.g_re == 32'h0 && out_data.g_im == 32'h0 && !out_data.saturated))
        else $error("zero denominator result not cleared");

    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.saturated) |->
            (out_data.g_re == 32'h7FFF_FFFF || out_data.g_re == 32'h8000_0000 ||
             out_data.g_im == 32'h7FFF_FFFF || out_data.g_im == 32'h8000_0000))
        else $error("saturated flag without a clipped part");

endmodule
